>>> src/lsra_pkg.sv
// ----------------------------------------------------------------------------
// lsra_pkg: shared types and constants
// Register file size, size codes, status codes and first-fit mask candidates
// for the linear-scan register allocator.
// ----------------------------------------------------------------------------
package lsra_pkg;

   localparam int REG_COUNT = 7;
   localparam int IDX_BITS  = 3;
   localparam int SIZE_BITS = 4;
   localparam int STAT_BITS = 2;

   localparam logic [SIZE_BITS-1:0] SIZE_BYTE = 4'd1;
   localparam logic [SIZE_BITS-1:0] SIZE_HALF = 4'd2;
   localparam logic [SIZE_BITS-1:0] SIZE_WORD = 4'd4;

   localparam logic [STAT_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_BITS-1:0] STATUS_BAD_SIZE = 2'd1;
   localparam logic [STAT_BITS-1:0] STATUS_NO_REGS  = 2'd2;
   localparam logic [STAT_BITS-1:0] STATUS_NO_SPILL = 2'd3;

   localparam logic [REG_COUNT-1:0] PAIR_MASK [3] = '{7'h03, 7'h0C, 7'h30};
   localparam logic [REG_COUNT-1:0] QUAD_MASK [2] = '{7'h0F, 7'h3C};

   typedef struct packed {
      logic                 spill;
      logic                 bad;
      logic [REG_COUNT-1:0] mask;
   } pick_type;

endpackage

>>> src/linear_scan_register_allocator_top.sv
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_top: linear-scan register allocator
// Expires finished intervals, spills or allocates first-fit masks over a
// seven-register file and keeps the active list sorted by end point.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | id, start, end, size
//   rsp     | out       | rsp_valid / rsp_ready | id, mask, spilled, status, last
//
// A request passes through the expiry scan over the active entries, the spill
// choice and, when an entry is added, the ordered insertion that shifts later
// entries up, all through one comparator, and then emits its results. Reset
// clears the state, busy mask, active valid bits, rsp valid and result select and count.
// req_ready is low from acceptance until the last result is loaded into the
// output register; a stalled rsp holds that register and the sequencer.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_top
   import lsra_pkg::*;
#(
   parameter int ID_BITS    = 8,
   parameter int POINT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ID_BITS-1:0]    req_interval_id,
   input  logic [POINT_BITS-1:0] req_start_point,
   input  logic [POINT_BITS-1:0] req_end_point,
   input  logic [SIZE_BITS-1:0]  req_size_bytes,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ID_BITS-1:0]    rsp_result_id,
   output logic [REG_COUNT-1:0]  rsp_reg_mask,
   output logic                  rsp_spilled,
   output logic [STAT_BITS-1:0]  rsp_status,
   output logic                  rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPIRE,
      ST_DECIDE,
      ST_INSERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    id;
      logic [POINT_BITS-1:0] end_pt;
      logic [REG_COUNT-1:0]  mask;
   } entry_type;

   typedef struct packed {
      logic [ID_BITS-1:0]   id;
      logic [REG_COUNT-1:0] mask;
      logic                 spilled;
      logic [STAT_BITS-1:0] status;
      logic                 last;
   } res_type;

   state_type             state_ff, state_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [POINT_BITS-1:0] start_ff, start_in;
   logic [POINT_BITS-1:0] end_ff, end_in;
   logic [SIZE_BITS-1:0]  size_ff, size_in;
   logic [REG_COUNT-1:0]  busy_ff, busy_in;
   logic [REG_COUNT-1:0]  valid_ff, valid_in;
   logic [IDX_BITS-1:0]   scan_ff, scan_in;
   logic [IDX_BITS-1:0]   wr_ff, wr_in;
   logic [IDX_BITS-1:0]   cnt_ff, cnt_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [REG_COUNT-1:0]  new_mask_ff, new_mask_in;
   res_type               res0_ff, res0_in;
   res_type               res1_ff, res1_in;
   logic                  res_num_ff, res_num_in;
   logic                  res_sel_ff, res_sel_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   res_type               rsp_ff, rsp_in;

   entry_type             entry_ff [REG_COUNT];
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   entry_type             wr_data;
   logic [IDX_BITS-1:0]   rd_addr;
   entry_type             rd_entry;

   logic [POINT_BITS-1:0] cmp_a;
   logic [POINT_BITS-1:0] cmp_b;
   logic                  cmp_lt;
   pick_type              pick;

   lsra_cmp #(
      .WIDTH(POINT_BITS)
   ) u_cmp (
      .a (cmp_a),
      .b (cmp_b),
      .lt(cmp_lt)
   );

   lsra_mask_pick u_pick (
      .busy(busy_ff),
      .size(size_ff),
      .pick(pick)
   );

   always_comb begin
      case (state_ff)
         ST_EXPIRE: rd_addr = (scan_ff == IDX_BITS'(REG_COUNT)) ? '0 : scan_ff;
         ST_DECIDE: rd_addr = (cnt_ff == '0) ? '0 : cnt_ff - 1'b1;
         ST_INSERT: rd_addr = (idx_ff == '0) ? '0 : idx_ff - 1'b1;
         default:   rd_addr = '0;
      endcase
      rd_entry = entry_ff[rd_addr];

      case (state_ff)
         ST_EXPIRE: begin
            cmp_a = rd_entry.end_pt;
            cmp_b = start_ff;
         end
         ST_DECIDE: begin
            cmp_a = end_ff;
            cmp_b = rd_entry.end_pt;
         end
         default: begin
            cmp_a = rd_entry.end_pt;
            cmp_b = end_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      id_in        = id_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      size_in      = size_ff;
      busy_in      = busy_ff;
      valid_in     = valid_ff;
      scan_in      = scan_ff;
      wr_in        = wr_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      new_mask_in  = new_mask_ff;
      res0_in      = res0_ff;
      res1_in      = res1_ff;
      res_num_in   = res_num_ff;
      res_sel_in   = res_sel_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = rd_entry;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               id_in    = req_interval_id;
               start_in = req_start_point;
               end_in   = req_end_point;
               size_in  = req_size_bytes;
               scan_in  = '0;
               wr_in    = '0;
               state_in = ST_EXPIRE;
            end
         end
         ST_EXPIRE: begin
            if ((scan_ff == IDX_BITS'(REG_COUNT)) || !valid_ff[rd_addr]) begin
               for (int k = 0; k < REG_COUNT; k++) begin
                  valid_in[k] = (IDX_BITS'(k) < wr_ff);
               end
               cnt_in   = wr_ff;
               state_in = ST_DECIDE;
            end else begin
               if (cmp_lt) begin
                  busy_in = busy_ff & ~rd_entry.mask;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = wr_ff;
                  wr_in   = wr_ff + 1'b1;
               end
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            res_sel_in = 1'b0;
            res_num_in = 1'b0;
            res0_in    = '{id: id_ff, mask: '0, spilled: 1'b0,
                           status: STATUS_OK, last: 1'b1};
            state_in   = ST_EMIT;
            if (pick.spill) begin
               if (cnt_ff == '0) begin
                  res0_in.status = STATUS_NO_SPILL;
               end else if (cmp_lt) begin
                  res0_in       = '{id: rd_entry.id, mask: '0, spilled: 1'b1,
                                    status: STATUS_OK, last: 1'b0};
                  res1_in       = '{id: id_ff, mask: rd_entry.mask, spilled: 1'b0,
                                    status: STATUS_OK, last: 1'b1};
                  res_num_in    = 1'b1;
                  valid_in[rd_addr] = 1'b0;
                  cnt_in        = cnt_ff - 1'b1;
                  idx_in        = cnt_ff - 1'b1;
                  new_mask_in   = rd_entry.mask;
                  state_in      = ST_INSERT;
               end else begin
                  res0_in.spilled = 1'b1;
               end
            end else if (pick.bad) begin
               res0_in.status = STATUS_BAD_SIZE;
            end else if (pick.mask == '0) begin
               res0_in.status = STATUS_NO_REGS;
            end else begin
               busy_in      = busy_ff | pick.mask;
               res0_in.mask = pick.mask;
               new_mask_in  = pick.mask;
               idx_in       = cnt_ff;
               if (cnt_ff != IDX_BITS'(REG_COUNT)) begin
                  state_in = ST_INSERT;
               end
            end
         end
         ST_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if ((idx_ff == '0) || cmp_lt) begin
               wr_data          = '{id: id_ff, end_pt: end_ff, mask: new_mask_ff};
               valid_in[cnt_ff] = 1'b1;
               state_in         = ST_EMIT;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_sel_ff ? res1_ff : res0_ff;
               if (res_sel_ff == res_num_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  res_sel_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         res_sel_ff   <= 1'b0;
         res_num_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         res_sel_ff   <= res_sel_in;
         res_num_ff   <= res_num_in;
      end
      id_ff       <= id_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      size_ff     <= size_in;
      scan_ff     <= scan_in;
      wr_ff       <= wr_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      new_mask_ff <= new_mask_in;
      res0_ff     <= res0_in;
      res1_ff     <= res1_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_id = rsp_ff.id;
   assign rsp_reg_mask  = rsp_ff.mask;
   assign rsp_spilled   = rsp_ff.spilled;
   assign rsp_status    = rsp_ff.status;
   assign rsp_last      = rsp_ff.last;

   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |->
         ((valid_ff & REG_COUNT'(valid_ff + 1'b1)) == '0))
      else $error("active list not packed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while sequencer busy");

   a_error_no_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |->
         ((rsp_reg_mask == '0) && !rsp_spilled && rsp_last))
      else $error("error result carries allocation");

   a_spill_no_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_spilled) |-> (rsp_reg_mask == '0))
      else $error("spilled result carries mask");

endmodule

>>> src/lsra_cmp.sv
// ----------------------------------------------------------------------------
// lsra_cmp: shared point comparator
// Unsigned less-than used by expiry, spill choice and ordered insertion.
// ----------------------------------------------------------------------------
module lsra_cmp #(
   parameter int WIDTH = 16
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   output logic             lt
);

   assign lt = (a < b);

endmodule

>>> src/lsra_mask_pick.sv
// ----------------------------------------------------------------------------
// lsra_mask_pick: spill test and first-fit register mask
// Flags the spill path from busy count plus size, flags bad sizes and picks
// the lowest free one-register, even-aligned two-register or even-based four-register mask.
// ----------------------------------------------------------------------------
module lsra_mask_pick
   import lsra_pkg::*;
(
   input  logic [REG_COUNT-1:0] busy,
   input  logic [SIZE_BITS-1:0] size,
   output pick_type             pick
);

   logic [IDX_BITS-1:0]    busy_cnt;
   logic [SIZE_BITS:0]     need;
   logic [REG_COUNT-1:0]   one_mask;
   logic [REG_COUNT-1:0]   pair_sel;
   logic [REG_COUNT-1:0]   quad_sel;

   always_comb begin
      busy_cnt = '0;
      for (int k = 0; k < REG_COUNT; k++) begin
         busy_cnt = busy_cnt + IDX_BITS'(busy[k]);
      end
      need = {2'b00, busy_cnt} + {1'b0, size};

      one_mask = '0;
      for (int k = REG_COUNT - 1; k >= 0; k--) begin
         if (!busy[k]) begin
            one_mask = REG_COUNT'(1) << k;
         end
      end

      pair_sel = '0;
      for (int k = 2; k >= 0; k--) begin
         if ((busy & PAIR_MASK[k]) == '0) begin
            pair_sel = PAIR_MASK[k];
         end
      end

      quad_sel = '0;
      for (int k = 1; k >= 0; k--) begin
         if ((busy & QUAD_MASK[k]) == '0) begin
            quad_sel = QUAD_MASK[k];
         end
      end

      pick.spill = (need > (SIZE_BITS+1)'(REG_COUNT));
      pick.bad   = 1'b0;
      case (size)
         SIZE_BYTE: pick.mask = one_mask;
         SIZE_HALF: pick.mask = pair_sel;
         SIZE_WORD: pick.mask = quad_sel;
         default: begin
            pick.mask = '0;
            pick.bad  = 1'b1;
         end
      endcase
   end

endmodule

>>> sim/linear_scan_register_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// linear_scan_register_allocator_top_tb: self-checking allocator testbench
// Drives live intervals into the allocator and tracks its own copy of the
// busy registers and the end-ordered active list. From these it predicts the
// grant, spill and error results of every accepted request. Directed cases
// come first, then random well-formed interval runs mixed with noise. Both
// channels idle at random, with one long response hold-off and several drain
// pauses.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator_top_tb;
   import lsra_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 30;

   typedef struct {
      logic [7:0]           id;
      logic [15:0]          first_pt;
      logic [15:0]          stop_pt;
      logic [SIZE_BITS-1:0] size;
      bit                   drain;
   } interval_type;

   typedef struct {
      logic [7:0]           id;
      logic [REG_COUNT-1:0] mask;
      logic                 spilled;
      logic [STAT_BITS-1:0] status;
      logic                 last;
   } grant_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_interval_id = '0;
   logic [15:0]          req_start_point = '0;
   logic [15:0]          req_end_point = '0;
   logic [SIZE_BITS-1:0] req_size_bytes = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_result_id;
   logic [REG_COUNT-1:0] rsp_reg_mask;
   logic                 rsp_spilled;
   logic [STAT_BITS-1:0] rsp_status;
   logic                 rsp_last;

   interval_type interval_q[$];
   grant_type    expected_grants[$];
   interval_type offered;
   grant_type    oldest;
   int        accepted_reqs = 0;
   int        total_reqs = 0;
   int        mismatches = 0;
   int        results_seen = 0;
   int        cycles = 0;
   int        hold_cycles = 0;
   bit        hold_done = 1'b0;
   logic [REG_COUNT-1:0] busy_set = '0;
   logic [7:0]           live_id   [REG_COUNT];
   logic [15:0]          live_end  [REG_COUNT];
   logic [REG_COUNT-1:0] live_mask [REG_COUNT];
   int                   live_count = 0;
   wire                  calm = accepted_reqs >= 600 && accepted_reqs < 800;

   linear_scan_register_allocator_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_interval_id (req_interval_id),
      .req_start_point (req_start_point),
      .req_end_point   (req_end_point),
      .req_size_bytes  (req_size_bytes),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_id   (rsp_result_id),
      .rsp_reg_mask    (rsp_reg_mask),
      .rsp_spilled     (rsp_spilled),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   task automatic report_mismatch(input string msg);
      $display("result %0d: %s", results_seen, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   function automatic void queue_interval(input int id, input int first_pt,
                                          input int stop_pt, input int size,
                                          input int drain);
      interval_type iv;
      iv.id = id[7:0];
      iv.first_pt = first_pt[15:0];
      iv.stop_pt = stop_pt[15:0];
      iv.size = size[SIZE_BITS-1:0];
      iv.drain = (drain != 0);
      interval_q.insert(interval_q.size(), iv);
   endfunction

   function automatic void expect_grant(input logic [7:0] id,
                                        input logic [REG_COUNT-1:0] mask,
                                        input logic spilled,
                                        input logic [STAT_BITS-1:0] status,
                                        input logic last);
      grant_type g;
      g.id = id;
      g.mask = mask;
      g.spilled = spilled;
      g.status = status;
      g.last = last;
      expected_grants.insert(expected_grants.size(), g);
   endfunction

   function automatic void insert_live(input logic [7:0] id, input logic [15:0] stop_pt,
                                       input logic [REG_COUNT-1:0] mask);
      int pos;
      if (live_count >= REG_COUNT) return;
      pos = 0;
      while (pos < live_count && live_end[pos] < stop_pt) pos++;
      for (int i = live_count; i > pos; i--) begin
         live_id[i] = live_id[i-1];
         live_end[i] = live_end[i-1];
         live_mask[i] = live_mask[i-1];
      end
      live_id[pos] = id;
      live_end[pos] = stop_pt;
      live_mask[pos] = mask;
      live_count++;
   endfunction

   function automatic void allocate_interval(input interval_type iv);
      int                   keep;
      logic [REG_COUNT-1:0] pick;
      logic [REG_COUNT-1:0] cand;
      keep = 0;
      for (int i = 0; i < live_count; i++) begin
         if (live_end[i] < iv.first_pt) begin
            busy_set &= ~live_mask[i];
         end else begin
            live_id[keep] = live_id[i];
            live_end[keep] = live_end[i];
            live_mask[keep] = live_mask[i];
            keep++;
         end
      end
      live_count = keep;
      if ($countones(busy_set) + int'(iv.size) > REG_COUNT) begin
         if (live_count == 0) begin
            expect_grant(iv.id, '0, 1'b0, STATUS_NO_SPILL, 1'b1);
         end else if (live_end[live_count-1] > iv.stop_pt) begin
            pick = live_mask[live_count-1];
            expect_grant(live_id[live_count-1], '0, 1'b1, STATUS_OK, 1'b0);
            live_count--;
            insert_live(iv.id, iv.stop_pt, pick);
            expect_grant(iv.id, pick, 1'b0, STATUS_OK, 1'b1);
         end else begin
            expect_grant(iv.id, '0, 1'b1, STATUS_OK, 1'b1);
         end
         return;
      end
      pick = '0;
      case (iv.size)
         SIZE_BYTE: begin
            for (int i = 0; i < REG_COUNT; i++)
               if (pick == '0 && !busy_set[i]) pick[i] = 1'b1;
         end
         SIZE_HALF: begin
            for (int i = 0; i < 3; i++) begin
               cand = 7'h03 << (2 * i);
               if (pick == '0 && (busy_set & cand) == '0) pick = cand;
            end
         end
         SIZE_WORD: begin
            for (int i = 0; i < 2; i++) begin
               cand = 7'h0F << (2 * i);
               if (pick == '0 && (busy_set & cand) == '0) pick = cand;
            end
         end
         default: begin
            expect_grant(iv.id, '0, 1'b0, STATUS_BAD_SIZE, 1'b1);
            return;
         end
      endcase
      if (pick == '0) begin
         expect_grant(iv.id, '0, 1'b0, STATUS_NO_REGS, 1'b1);
      end else begin
         busy_set |= pick;
         insert_live(iv.id, iv.stop_pt, pick);
         expect_grant(iv.id, pick, 1'b0, STATUS_OK, 1'b1);
      end
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("linear_scan_register_allocator_top_tb: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            allocate_interval(offered);
            accepted_reqs <= accepted_reqs + 1;
         end
         if (req_valid && !req_ready) begin
         end else if (interval_q.size() > 0 &&
                      !(interval_q[0].drain && (expected_grants.size() != 0 || rsp_valid)) &&
                      (calm || $urandom_range(0, 99) >= 31)) begin
            offered = interval_q.pop_front();
            req_valid <= 1'b1;
            req_interval_id <= offered.id;
            req_start_point <= offered.first_pt;
            req_end_point <= offered.stop_pt;
            req_size_bytes <= offered.size;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && accepted_reqs >= 300) begin
         hold_cycles <= 200;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || $urandom_range(0, 99) >= 31;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_grants.size() == 0) begin
            report_mismatch($sformatf("unexpected result for id %0h", rsp_result_id));
         end else begin
            oldest = expected_grants.pop_front();
            check_field("result_id", 16'(rsp_result_id), 16'(oldest.id));
            check_field("reg_mask", 16'(rsp_reg_mask), 16'(oldest.mask));
            check_field("spilled", 16'(rsp_spilled), 16'(oldest.spilled));
            check_field("status", 16'(rsp_status), 16'(oldest.status));
            check_field("last", 16'(rsp_last), 16'(oldest.last));
         end
         results_seen <= results_seen + 1;
      end
   end

   initial begin
      int cursor;
      int run_len;
      int span;
      int stop_pt;
      int size;
      int pick;
      queue_interval(8'h00, 0, 100, 1, 0);
      queue_interval(8'hFF, 1, 200, 2, 0);
      queue_interval(8'h12, 2, 300, 4, 0);
      queue_interval(8'h13, 2, 100, 1, 0);
      queue_interval(8'h14, 3, 50, 0, 0);
      queue_interval(8'h15, 3, 50, 3, 0);
      queue_interval(8'h16, 3, 50, 7, 0);
      queue_interval(8'h17, 4, 65535, 2, 0);
      queue_interval(8'h18, 5, 65535, 4, 0);
      queue_interval(8'h19, 6, 40, 1, 0);
      queue_interval(8'h1A, 6, 0, 1, 0);
      queue_interval(8'h1B, 65535, 65535, 15, 0);
      queue_interval(8'h1C, 65535, 65535, 8, 0);
      queue_interval(8'h1D, 0, 16'hAAAA, 4, 0);
      queue_interval(8'h1E, 16'h5555, 16'h5555, 4, 0);
      queue_interval(8'h1F, 16'h5555, 16'hFFFF, 2, 0);
      queue_interval(8'h20, 16'h8000, 16'h8000, 1, 0);
      queue_interval(8'h21, 16'h8000, 16'h9000, 12, 0);
      queue_interval(8'hA5, 65535, 0, 1, 0);
      queue_interval(8'h5A, 65535, 65535, 1, 1);
      queue_interval(8'h22, 65535, 65535, 6, 0);
      cursor = 0;
      while (interval_q.size() < 1070) begin
         if ($urandom_range(0, 99) < 8) begin
            queue_interval($urandom_range(0, 255), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 15), 0);
         end else begin
            if ($urandom_range(0, 3) == 0 || cursor > 65000)
               cursor = $urandom_range(0, 65000);
            run_len = $urandom_range(4, 16);
            for (int k = 0; k < run_len; k++) begin
               cursor += $urandom_range(0, 6);
               case ($urandom_range(0, 9))
                  0: span = $urandom_range(0, 65535);
                  1, 2: span = $urandom_range(0, 400);
                  default: span = $urandom_range(0, 24);
               endcase
               stop_pt = cursor + span;
               if (stop_pt > 65535) stop_pt = 65535;
               pick = $urandom_range(0, 9);
               if (pick < 4) size = 1;
               else if (pick < 7) size = 2;
               else if (pick < 9) size = 4;
               else size = $urandom_range(0, 15);
               queue_interval($urandom_range(0, 255), cursor, stop_pt, size,
                              k == 0 && $urandom_range(0, 4) == 0);
            end
         end
      end
      total_reqs = interval_q.size();
      wait (accepted_reqs == total_reqs);
      wait (expected_grants.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_grants.size() == 0) begin
         $display("linear_scan_register_allocator_top_tb: clean");
      end else begin
         $display("linear_scan_register_allocator_top_tb: errors");
      end
      $finish;
   end

endmodule

>>> linear_scan_register_allocator_top.f
src/lsra_pkg.sv
src/lsra_cmp.sv
src/lsra_mask_pick.sv
src/linear_scan_register_allocator_top.sv
sim/linear_scan_register_allocator_top_tb.sv
